@@ hdl/gsap_pkg.sv @@
// Package of the gas sensor average-to-percent unit.
// Holds register widths, reset values, register indexes and the divider control type.
// No dependencies.
package gsap_pkg;

    // Defaults of the top-level parameters.
    localparam int MAX_SAMPLES_DEF = 64;
    localparam int ADC_BITS_DEF    = 12;

    // Configuration register widths and port format.
    localparam int RL_W      = 16;
    localparam int R0_W      = 20;
    localparam int FSR_W     = 10;
    localparam int SPR_W     = 7;
    localparam int CFG_W     = 20;
    localparam int CFG_IDX_W = 4;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_LOAD_RES  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLEAN_RES = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FS_RATIO  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLES   = 4'd3;

    // Register reset values.
    localparam logic [RL_W-1:0]  RL_RST  = 16'd5000;
    localparam logic [R0_W-1:0]  R0_RST  = 20'd18000;
    localparam logic [FSR_W-1:0] FSR_RST = 10'd300;
    localparam logic [SPR_W-1:0] SPR_RST = 7'd25;

    // Result field widths and limits.
    localparam int PCT_W = 14;
    localparam int RS_W  = 34;
    localparam logic [PCT_W-1:0] PCT_MAX = 14'd10000;
    localparam logic [FSR_W-1:0] FSR_MAX = 10'd999;
    localparam logic [FSR_W-1:0] MILLI   = 10'd1000;

    // Scale of the percent mapping: hundredths of a percent times thousandths.
    localparam int PCT_SCALE_W = 24;
    localparam logic [PCT_SCALE_W-1:0] PCT_SCALE = 24'd10_000_000;

    // Divider iteration count width; holds every dividend length used here.
    localparam int DIV_CNT_W = 6;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] nbits;
    } t_div_ctl;

endpackage

@@ hdl/gsap_div.sv @@
// Restoring divider of the gas sensor unit, one quotient bit per cycle.
// Depends on gsap_pkg for the control type and the iteration count width.
module gsap_div #(
    parameter int DVD_W = 44,
    parameter int DVS_W = 30
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  gsap_pkg::t_div_ctl    i_ctl,
    input  logic [DVD_W-1:0]      i_dividend,
    input  logic [DVS_W-1:0]      i_divisor,
    output logic                  o_done,
    output logic [DVD_W-1:0]      o_quotient
);
    import gsap_pkg::*;

    localparam logic [DIV_CNT_W-1:0] DVD_LEN = DIV_CNT_W'(DVD_W);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0]     r_q;
    logic [DVS_W-1:0]     r_rem;
    logic [DVS_W-1:0]     r_dvs;

    logic [DVS_W:0]       rem_sh;
    logic [DVS_W+1:0]     sub;
    logic                 ge;

    // The dividend is aligned so that its significant bits leave the top first.
    assign rem_sh = {r_rem, r_q[DVD_W-1]};
    assign sub    = {1'b0, rem_sh} - {2'b00, r_dvs};
    assign ge     = !sub[DVS_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_ctl.nbits;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_q   <= i_dividend << (DVD_LEN - i_ctl.nbits);
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[DVD_W-2:0], ge};
            r_rem <= ge ? sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("divider done held for more than one cycle");
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.start |-> !r_busy)
        else $error("divider started while busy");
    a_busy_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt != '0)
        else $error("divider busy with no iterations left");

endmodule

@@ hdl/gas_sensor_average_to_percent_unit.sv @@
// Gas sensor averager and percent mapper; depends on gsap_pkg and the gsap_div divider.
// An item that closes no reading leaves the unit idle. The item that closes a reading
// starts the average, resistance and percent steps in that order, with divisions of SUM_W,
// SUM_W+16 and 44 bits; a zero sum skips all three, a resistance at or above R0 skips the last.
// Input is not ready meanwhile, nor while the reading waits for the output register.
// Reset: synchronous, active low.
module gas_sensor_average_to_percent_unit #(
    parameter int MAX_SAMPLES = gsap_pkg::MAX_SAMPLES_DEF,
    parameter int ADC_BITS    = gsap_pkg::ADC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Configuration write port.
    input  logic                                 i_cfg_we,
    input  logic [gsap_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [gsap_pkg::CFG_W-1:0]           i_cfg_wdata,
    // Sample stream. tdata: adc_sample, then zero padding.
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    input  logic [((ADC_BITS+7)/8)*8-1:0]         i_s_tdata,
    // Reading stream. tdata from bit 0: pollution_hundredths, sensor_resistance_ohms,
    // average_raw, then zero padding.
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    output logic [((gsap_pkg::PCT_W+gsap_pkg::RS_W+ADC_BITS+7)/8)*8-1:0] o_m_tdata,
    // tuser: zero_signal_fault.
    output logic                                 o_m_tuser
);
    import gsap_pkg::*;

    localparam int OUT_W     = ((PCT_W + RS_W + ADC_BITS + 7) / 8) * 8;
    localparam int FULL      = (1 << ADC_BITS) - 1;
    localparam int SUM_W     = $clog2(MAX_SAMPLES * FULL + 1);
    localparam int CNT_W     = $clog2(MAX_SAMPLES + 1);
    localparam int EFF_W     = (CNT_W > SPR_W) ? CNT_W : SPR_W;
    localparam int MUL_B_W   = (SUM_W > R0_W) ? SUM_W : R0_W;
    localparam int DVD_W     = PCT_SCALE_W + MUL_B_W;
    localparam int DEN_W     = R0_W + FSR_W;
    localparam int DVS_W     = (SUM_W > DEN_W) ? SUM_W : DEN_W;
    localparam int RSNUM_W   = RL_W + SUM_W;
    localparam int PCTNUM_W  = PCT_SCALE_W + R0_W;

    // Sequencer states.
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CHECK  = 4'd1;
    localparam logic [3:0] S_AVG    = 4'd2;
    localparam logic [3:0] S_MULRS  = 4'd3;
    localparam logic [3:0] S_RSGO   = 4'd4;
    localparam logic [3:0] S_RS     = 4'd5;
    localparam logic [3:0] S_MULDEN = 4'd6;
    localparam logic [3:0] S_MULNUM = 4'd7;
    localparam logic [3:0] S_PCTGO  = 4'd8;
    localparam logic [3:0] S_PCT    = 4'd9;
    localparam logic [3:0] S_OUT    = 4'd10;

    // Configuration registers.
    logic [RL_W-1:0]  r_rl;
    logic [R0_W-1:0]  r_r0;
    logic [FSR_W-1:0] r_fsr;
    logic [SPR_W-1:0] r_spr;

    // Accumulation and sequencer state.
    logic [3:0]       r_state;
    logic [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0] r_cnt;

    // Working registers of one reading.
    logic [SUM_W-1:0]    r_tot;
    logic [CNT_W-1:0]    r_k;
    logic [SUM_W-1:0]    r_diff;
    logic [DVD_W-1:0]    r_prod;
    logic [DEN_W-1:0]    r_den;
    logic [PCT_W-1:0]    r_pct;
    logic [RS_W-1:0]     r_rs;
    logic [ADC_BITS-1:0] r_avg;
    logic                r_fault;

    // Output register.
    logic             r_m_valid;
    logic [OUT_W-1:0] r_m_data;
    logic             r_m_user;

    logic                 in_acc;
    logic [SUM_W-1:0]     n_sum;
    logic [CNT_W-1:0]     n_cnt;
    logic [EFF_W-1:0]     eff;
    logic                 reading_due;
    logic [SUM_W:0]       kfs;
    logic [FSR_W-1:0]     fsr_eff;
    logic                 r0_above;
    logic                 out_free;

    logic [PCT_SCALE_W-1:0] mul_a;
    logic [MUL_B_W-1:0]     mul_b;
    logic [DVD_W-1:0]       mul_p;

    t_div_ctl             div_ctl;
    logic [DVD_W-1:0]     div_dvd;
    logic [DVS_W-1:0]     div_dvs;
    logic                 div_done;
    logic [DVD_W-1:0]     div_q;

    // Register writes; indexes past the list fall through and change nothing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rl  <= RL_RST;
            r_r0  <= R0_RST;
            r_fsr <= FSR_RST;
            r_spr <= SPR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_LOAD_RES:  r_rl  <= i_cfg_wdata[RL_W-1:0];
                REG_CLEAN_RES: r_r0  <= i_cfg_wdata[R0_W-1:0];
                REG_FS_RATIO:  r_fsr <= i_cfg_wdata[FSR_W-1:0];
                REG_SAMPLES:   r_spr <= i_cfg_wdata[SPR_W-1:0];
                default: ;
            endcase
        end
    end

    // The sample count register is read as 1 when zero and capped at the sum capacity.
    always_comb begin
        if (r_spr == '0) begin
            eff = EFF_W'(1);
        end else if (EFF_W'(r_spr) > EFF_W'(MAX_SAMPLES)) begin
            eff = EFF_W'(MAX_SAMPLES);
        end else begin
            eff = EFF_W'(r_spr);
        end
    end

    assign o_s_tready  = (r_state == S_IDLE);
    assign in_acc      = i_s_tvalid && o_s_tready;
    assign n_sum       = r_sum + SUM_W'(i_s_tdata[ADC_BITS-1:0]);
    assign n_cnt       = r_cnt + 1'b1;
    assign reading_due = (EFF_W'(n_cnt) >= eff);

    // Full scale times the sample count, as a shift and a subtract.
    assign kfs     = ((SUM_W+1)'(r_k) << ADC_BITS) - (SUM_W+1)'(r_k);
    assign fsr_eff = (r_fsr > FSR_MAX) ? FSR_MAX : r_fsr;
    assign r0_above = ((RS_W'(r_r0)) > r_rs);
    assign out_free = !r_m_valid || i_m_tready;

    // The one multiplier, shared by the three products of a reading.
    always_comb begin
        unique case (r_state)
            S_MULRS: begin
                mul_a = PCT_SCALE_W'(r_rl);
                mul_b = MUL_B_W'(r_diff);
            end
            S_MULDEN: begin
                mul_a = PCT_SCALE_W'(MILLI - fsr_eff);
                mul_b = MUL_B_W'(r_r0);
            end
            S_MULNUM: begin
                mul_a = PCT_SCALE;
                mul_b = MUL_B_W'(r_r0 - r_rs[R0_W-1:0]);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p = DVD_W'(mul_a) * DVD_W'(mul_b);

    // Divider operands follow the step that starts it.
    always_comb begin
        div_ctl = '0;
        div_dvd = '0;
        div_dvs = '0;
        unique case (r_state)
            S_CHECK: begin
                div_ctl.start = (r_tot != '0);
                div_ctl.nbits = DIV_CNT_W'(SUM_W);
                div_dvd       = DVD_W'(r_tot);
                div_dvs       = DVS_W'(r_k);
            end
            S_RSGO: begin
                div_ctl.start = 1'b1;
                div_ctl.nbits = DIV_CNT_W'(RSNUM_W);
                div_dvd       = r_prod;
                div_dvs       = DVS_W'(r_tot);
            end
            S_PCTGO: begin
                div_ctl.start = 1'b1;
                div_ctl.nbits = DIV_CNT_W'(PCTNUM_W);
                div_dvd       = r_prod;
                div_dvs       = DVS_W'(r_den);
            end
            default: ;
        endcase
    end

    gsap_div #(
        .DVD_W(DVD_W),
        .DVS_W(DVS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (div_ctl),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // Sequencer, running sum and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_sum     <= '0;
            r_cnt     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            // A new reading replaces the one taken at this edge, if any.
            if (r_state == S_OUT && out_free) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (reading_due) begin
                            r_sum   <= '0;
                            r_cnt   <= '0;
                            r_state <= S_CHECK;
                        end else begin
                            r_sum <= n_sum;
                            r_cnt <= n_cnt;
                        end
                    end
                end
                S_CHECK:  r_state <= (r_tot == '0) ? S_OUT : S_AVG;
                S_AVG:    if (div_done) r_state <= S_MULRS;
                S_MULRS:  r_state <= S_RSGO;
                S_RSGO:   r_state <= S_RS;
                S_RS:     if (div_done) r_state <= S_MULDEN;
                S_MULDEN: r_state <= S_MULNUM;
                S_MULNUM: r_state <= r0_above ? S_PCTGO : S_OUT;
                S_PCTGO:  r_state <= S_PCT;
                S_PCT:    if (div_done) r_state <= S_OUT;
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default:  r_state <= S_IDLE;
            endcase
        end
    end

    // Working registers of a reading; none of these needs a reset.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && reading_due) begin
                    r_tot <= n_sum;
                    r_k   <= n_cnt;
                end
            end
            S_CHECK: begin
                // A zero sum means an open sensor: saturated resistance and a fault.
                r_diff <= kfs[SUM_W-1:0] - r_tot;
                if (r_tot == '0) begin
                    r_pct   <= '0;
                    r_rs    <= '1;
                    r_avg   <= '0;
                    r_fault <= 1'b1;
                end else begin
                    r_fault <= 1'b0;
                end
            end
            S_AVG: if (div_done) r_avg <= div_q[ADC_BITS-1:0];
            S_MULRS: r_prod <= mul_p;
            S_RS: begin
                if (div_done) begin
                    r_rs <= (|div_q[DVD_W-1:RS_W]) ? '1 : div_q[RS_W-1:0];
                end
            end
            S_MULDEN: r_den <= mul_p[DEN_W-1:0];
            S_MULNUM: begin
                // A resistance at or above the clean-air value reads as no pollution.
                if (r0_above) begin
                    r_prod <= mul_p;
                end else begin
                    r_pct <= '0;
                end
            end
            S_PCT: begin
                if (div_done) begin
                    r_pct <= (div_q > DVD_W'(PCT_MAX)) ? PCT_MAX : div_q[PCT_W-1:0];
                end
            end
            default: ;
        endcase
    end

    // The output register lets accumulation go on while a reading waits to be taken.
    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_m_data <= OUT_W'({r_avg, r_rs, r_pct});
            r_m_user <= r_fault;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;

    a_sum_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> (r_sum == '0 && r_cnt == '0))
        else $error("running sum not cleared while a reading is computed");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt < CNT_W'(MAX_SAMPLES))
        else $error("sample count reached the sum capacity");
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_AVG || r_state == S_RS || r_state == S_PCT))
        else $error("divider finished outside a wait step");
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && out_free) |=> (o_m_tvalid && r_state == S_IDLE))
        else $error("finished reading not presented");

endmodule

@@ tb/sv/gas_sensor_reading_checker.sv @@
`timescale 1ns / 100ps
// Reading checker for the gas sensor average-to-percent unit: watches the register port and
// both streams, predicts every reading and compares it with what the unit sends.
// Depends on gsap_pkg for field widths, register indexes, reset values and limits.
module gas_sensor_reading_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [gsap_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [gsap_pkg::CFG_W-1:0]       i_cfg_wdata,
    input  logic                             i_s_tvalid,
    input  logic                             i_s_tready,
    input  logic [15:0]                      i_s_tdata,    // adc_sample, zero padding
    input  logic                             i_m_tvalid,
    input  logic                             i_m_tready,
    // pollution_hundredths, sensor_resistance_ohms, average_raw, zero padding
    input  logic [63:0]                      i_m_tdata,
    input  logic                             i_m_tuser,    // zero_signal_fault
    output int                               o_pending,
    output int                               o_errors
);
    import gsap_pkg::*;

    localparam int ADC_W  = ADC_BITS_DEF;
    localparam int RS_LO  = PCT_W;
    localparam int AVG_LO = PCT_W + RS_W;
    localparam logic [63:0] FULL_SCALE = (64'd1 << ADC_W) - 64'd1;
    localparam logic [63:0] RS_SAT     = (64'd1 << RS_W) - 64'd1;

    typedef struct packed {
        logic [PCT_W-1:0] pct;
        logic [RS_W-1:0]  rs;
        logic [ADC_W-1:0] avg;
        logic             fault;
    } t_reading;

    t_reading readings_due[$];

    // Shadow copies of the registers and of the accumulator.
    logic [RL_W-1:0]  load_res;
    logic [R0_W-1:0]  clean_res;
    logic [FSR_W-1:0] fs_ratio;
    logic [SPR_W-1:0] samples_cfg;
    logic [17:0]      acc_sum;
    logic [SPR_W-1:0] acc_count;
    int               mismatches = 0;

    always @(posedge i_clk) begin : watch
        logic [63:0]      k, sum, rs, pct, r0, fsr;
        logic [SPR_W-1:0] need;
        t_reading         want, got;
        if (!i_rst_n) begin
            load_res    = RL_RST;
            clean_res   = R0_RST;
            fs_ratio    = FSR_RST;
            samples_cfg = SPR_RST;
            acc_sum     = '0;
            acc_count   = '0;
            readings_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_LOAD_RES:  load_res    = i_cfg_wdata[RL_W-1:0];
                    REG_CLEAN_RES: clean_res   = i_cfg_wdata[R0_W-1:0];
                    REG_FS_RATIO:  fs_ratio    = i_cfg_wdata[FSR_W-1:0];
                    REG_SAMPLES:   samples_cfg = i_cfg_wdata[SPR_W-1:0];
                    default: ;
                endcase
            end

            if (i_s_tvalid && i_s_tready) begin
                acc_sum   = acc_sum + 18'(i_s_tdata[ADC_W-1:0]);
                acc_count = acc_count + 1'b1;
                // A count of zero acts as one, anything above the maximum as the maximum.
                need = samples_cfg;
                if (need == '0) need = SPR_W'(1);
                if (need > SPR_W'(MAX_SAMPLES_DEF)) need = SPR_W'(MAX_SAMPLES_DEF);
                if (acc_count >= need) begin
                    k   = 64'(acc_count);
                    sum = 64'(acc_sum);
                    acc_sum   = '0;
                    acc_count = '0;
                    if (sum == '0) begin
                        // Open sensor: saturated resistance and a fault flag.
                        want.pct   = '0;
                        want.rs    = RS_SAT[RS_W-1:0];
                        want.avg   = '0;
                        want.fault = 1'b1;
                    end else begin
                        rs = (64'(load_res) * (FULL_SCALE * k - sum)) / sum;
                        if (rs > RS_SAT) rs = RS_SAT;
                        r0  = 64'(clean_res);
                        fsr = 64'(fs_ratio);
                        if (fsr > 64'(FSR_MAX)) fsr = 64'(FSR_MAX);
                        if (r0 > rs) begin
                            pct = (64'(PCT_SCALE) * (r0 - rs)) / (r0 * (64'(MILLI) - fsr));
                            if (pct > 64'(PCT_MAX)) pct = 64'(PCT_MAX);
                        end else begin
                            pct = '0;
                        end
                        want.pct   = pct[PCT_W-1:0];
                        want.rs    = rs[RS_W-1:0];
                        want.avg   = ADC_W'(sum / k);
                        want.fault = 1'b0;
                    end
                    readings_due.push_back(want);
                end
            end

            if (i_m_tvalid && i_m_tready) begin
                got.pct   = i_m_tdata[PCT_W-1:0];
                got.rs    = i_m_tdata[RS_LO +: RS_W];
                got.avg   = i_m_tdata[AVG_LO +: ADC_W];
                got.fault = i_m_tuser;
                if (readings_due.size() == 0) begin
                    $error("reading with none expected: pct %0d rs %0d avg %0d fault %0b",
                           got.pct, got.rs, got.avg, got.fault);
                    mismatches++;
                end else begin
                    want = readings_due.pop_front();
                    if (got.pct !== want.pct) begin
                        $error("pollution_hundredths: expected %0d, actual %0d",
                               want.pct, got.pct);
                        mismatches++;
                    end
                    if (got.rs !== want.rs) begin
                        $error("sensor_resistance_ohms: expected %0d, actual %0d",
                               want.rs, got.rs);
                        mismatches++;
                    end
                    if (got.avg !== want.avg) begin
                        $error("average_raw: expected %0d, actual %0d", want.avg, got.avg);
                        mismatches++;
                    end
                    if (got.fault !== want.fault) begin
                        $error("zero_signal_fault: expected %0b, actual %0b",
                               want.fault, got.fault);
                        mismatches++;
                    end
                end
            end
        end
        o_pending <= readings_due.size();
        o_errors  <= mismatches;
    end

endmodule

@@ tb/sv/gas_sensor_average_to_percent_unit_tb.sv @@
`timescale 1ns / 100ps
// Top of the testbench for the gas sensor average-to-percent unit: clock, reset, register
// writes, sample stimulus, reading back-pressure and the verdict.
// Depends on gsap_pkg, the unit itself and gas_sensor_reading_checker.
module gas_sensor_average_to_percent_unit_tb;
    import gsap_pkg::*;

    localparam int ADC_W = ADC_BITS_DEF;
    localparam int S_W   = ((ADC_W + 7) / 8) * 8;
    localparam int M_W   = ((PCT_W + RS_W + ADC_W + 7) / 8) * 8;

    // A register index past the end of the list; the unit must ignore writes to it.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd9;

    // Margin after the last expected reading has come, so that no item is still in flight
    // when registers change.
    localparam int SETTLE_CYCLES = 160;
    // Watchdog limit: the slowest legal run, every item closing a reading, with the longest
    // receiver stall and sender gap, stays well under it.
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_PHASES = 14;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx   = '0;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;
    logic                 i_s_tvalid  = 1'b0;
    logic [S_W-1:0]       i_s_tdata   = '0;
    logic                 i_m_tready  = 1'b0;
    wire                  o_s_tready;
    wire                  o_m_tvalid;
    wire  [M_W-1:0]       o_m_tdata;
    wire                  o_m_tuser;

    int readings_pending;
    int error_count;
    int cycle_count = 0;

    // Samples waiting to be sent by the streaming task, in order.
    logic [ADC_W-1:0] sample_fifo[$];

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    gas_sensor_average_to_percent_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),     // adc_sample, zero padding
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),     // pollution_hundredths, sensor_resistance_ohms, average_raw
        .o_m_tuser   (o_m_tuser)      // zero_signal_fault
    );

    gas_sensor_reading_checker checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_m_tdata   (o_m_tdata),
        .i_m_tuser   (o_m_tuser),
        .o_pending   (readings_pending),
        .o_errors    (error_count)
    );

    // The reading side cycles through four stall styles in turn: always ready,
    // mostly ready, a fixed duty pattern, and mostly stalled.
    logic [8:0] rx_tick = '0;
    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 1'b1;
        case (rx_tick[8:7])
            2'd0:    i_m_tready <= 1'b1;
            2'd1:    i_m_tready <= ($urandom_range(0, 3) != 0);
            2'd2:    i_m_tready <= (rx_tick[3:0] < 4'd5);
            default: i_m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Watchdog: a hung unit must still end the run with a verdict.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Places one register write on the port. The caller lowers the write enable once its
    // batch of writes is done, so the enable is never dropped and raised in the same step.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
    endtask

    task automatic set_regs(input int rl, input int r0, input int fsr, input int spr);
        cfg_write(REG_LOAD_RES,  CFG_W'(rl));
        cfg_write(REG_CLEAN_RES, CFG_W'(r0));
        cfg_write(REG_FS_RATIO,  CFG_W'(fsr));
        cfg_write(REG_SAMPLES,   CFG_W'(spr));
        i_cfg_we <= 1'b0;
    endtask

    // Sends every queued sample. Items go out in bursts of random length; tvalid drops
    // between bursts for a random gap and is always low when the task returns.
    task automatic send_all();
        int burst_left;
        burst_left = 0;
        while (sample_fifo.size() > 0) begin
            if (burst_left == 0) begin
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(1, 6);
            end
            i_s_tdata  <= {{(S_W - ADC_W){1'b0}}, sample_fifo.pop_front()};
            i_s_tvalid <= 1'b1;
            do @(posedge i_clk); while (!o_s_tready);
            burst_left--;
            if (burst_left == 0 || sample_fifo.size() == 0) begin
                i_s_tvalid <= 1'b0;
                repeat (($urandom_range(0, 4) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(1, 4)) @(posedge i_clk);
            end
        end
    endtask

    // Holds off the sender until every predicted reading has come back, then lets the
    // unit finish any item that closes no reading.
    task automatic settle();
        @(posedge i_clk);
        while (readings_pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int phase, items, target, chunk, style, level, s, rl, r0, fsr, spr, i;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Smallest registers, one sample per reading: a zero sample gives the open-sensor
        // fault, full scale gives zero resistance and exactly 100 percent, and a sample
        // of one gives a resistance far above R0, hence zero percent.
        set_regs(1, 1, 0, 1);
        sample_fifo = '{12'd0, 12'd4095, 12'd1};
        send_all();
        settle();

        // Largest registers. A ratio register above 999 must act as 999, and a sample
        // count of zero must act as one.
        set_regs(16'hFFFF, 20'hFFFFF, 10'h3FF, 0);
        sample_fifo = '{12'd1, 12'd2048, 12'd4095, 12'd0};
        send_all();
        settle();

        // A write to an index past the list must leave every register alone.
        cfg_write(REG_UNUSED, CFG_W'($urandom));
        i_cfg_we <= 1'b0;
        sample_fifo = '{12'd1365, 12'd3000};
        send_all();
        settle();

        // Two-sample readings, other registers at reset values: an all-zero pair, a full-scale pair.
        set_regs(RL_RST, R0_RST, FSR_RST, 2);
        sample_fifo = '{12'd0, 12'd0, 12'd4095, 12'd4095};
        send_all();
        settle();

        // Raising the sample count, then lowering it while a reading is partly gathered: the next sample
        // closes the reading with both samples in the sum.
        cfg_write(REG_SAMPLES, CFG_W'(3));
        i_cfg_we <= 1'b0;
        sample_fifo = '{12'd2500};
        send_all();
        settle();
        cfg_write(REG_SAMPLES, CFG_W'(1));
        i_cfg_we <= 1'b0;
        sample_fifo = '{12'd700};
        send_all();
        settle();

        // Zero clean-air resistance: the resistance can never be below it, so zero percent.
        set_regs(RL_RST, 0, FSR_RST, 1);
        sample_fifo = '{12'd4095, 12'd2047};
        send_all();
        settle();

        // Random phases. Each one picks registers, extremes among them, and then sends
        // whole readings in one style at a time: spread samples, a steady level with noise
        // (the realistic case), all zeros, or values stuck near either rail.
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case ($urandom_range(0, 5))
                0:       rl = 0;
                1:       rl = 1;
                2:       rl = 65535;
                default: rl = $urandom_range(100, 20000);
            endcase
            case ($urandom_range(0, 6))
                0:       r0 = 0;
                1:       r0 = 1;
                2:       r0 = 20'hFFFFF;
                default: r0 = (rl * $urandom_range(1, 4) + $urandom_range(0, 999)) & 20'hFFFFF;
            endcase
            case ($urandom_range(0, 4))
                0:       fsr = 0;
                1:       fsr = 999;
                2:       fsr = 1023;
                default: fsr = $urandom_range(0, 1023);
            endcase
            case ($urandom_range(0, 7))
                0:       spr = 0;
                1:       spr = 64;
                2:       spr = $urandom_range(65, 127);
                3:       spr = 25;
                default: spr = $urandom_range(1, 8);
            endcase
            set_regs(rl, r0, fsr, spr);

            // Chunks follow the effective sample count, so most readings are formed from
            // one style only.
            chunk  = (spr == 0) ? 1 : (spr > MAX_SAMPLES_DEF) ? MAX_SAMPLES_DEF : spr;
            target = $urandom_range(60, 90);
            items  = 0;
            while (items < target) begin
                style = $urandom_range(0, 4);
                level = $urandom_range(0, 4095);
                for (i = 0; i < chunk; i++) begin
                    case (style)
                        0: s = $urandom_range(0, 4095);
                        1, 2: begin
                            s = level + $urandom_range(0, 64) - 32;
                            if (s < 0) s = 0;
                            if (s > 4095) s = 4095;
                        end
                        3: s = 0;
                        default: s = ($urandom_range(0, 1) != 0) ? $urandom_range(4088, 4095)
                                                                  : $urandom_range(0, 7);
                    endcase
                    sample_fifo.push_back(ADC_W'(s));
                end
                items += chunk;
            end
            send_all();
            settle();
        end

        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/gsap_pkg.sv
hdl/gsap_div.sv
hdl/gas_sensor_average_to_percent_unit.sv
tb/sv/gas_sensor_reading_checker.sv
tb/sv/gas_sensor_average_to_percent_unit_tb.sv
